// ----- hw/rtl/lcdbuf_pkg.sv -----
// ---------------------------------------------------------------------------
// lcdbuf_pkg: shared types and constants for the character lcd buffer
// Grid geometry, beat structs, operation codes and the fixed command bytes.
// ---------------------------------------------------------------------------
`default_nettype none

package lcdbuf_pkg;

	// grid geometry
	localparam int COLUMNS = 20;
	localparam int ROWS    = 2;
	localparam int CELLS   = ROWS * COLUMNS;
	localparam int CELL_W  = $clog2(CELLS);
	localparam int COL_W   = $clog2(COLUMNS);
	localparam int ROW_W   = (ROWS > 1) ? $clog2(ROWS) : 1;

	// wake-up sequence
	localparam int INIT_LEN = 5;
	localparam int STEP_W   = $clog2(INIT_LEN);

	localparam logic [7:0] CMD_ROW_ONE = 8'h80;
	localparam logic [7:0] CMD_ROW_TWO = 8'hC0;
	localparam logic [7:0] CHAR_SPACE  = 8'h20;

	typedef enum logic [1:0] {
		OP_INIT    = 2'd0,
		OP_WRITE   = 2'd1,
		OP_CLEAR   = 2'd2,
		OP_REFRESH = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_INIT,
		ST_REFRESH
	} state_t;

	typedef struct packed {
		op_t        op;
		logic [4:0] column;
		logic [1:0] row;
		logic [7:0] char_code;
	} item_t;

	typedef struct packed {
		logic       has_transfer;
		logic       register_select;
		logic [7:0] bus_byte;
		logic       nibble_only;
		logic       refresh_pending;
		logic       last;
	} result_t;

	// control broadcast to the cell chain
	typedef struct packed {
		logic              shift;
		logic              clear;
		logic              wr_en;
		logic [CELL_W-1:0] wr_index;
		logic [7:0]        char_code;
	} cell_ctrl_t;

	// wake-up command bytes, first one strobed as a lone high nibble
	function automatic logic [7:0] init_byte(input logic [STEP_W-1:0] step);
		logic [7:0] b;
		case (step)
			STEP_W'(0): b = 8'h20;
			STEP_W'(1): b = 8'h2C;
			STEP_W'(2): b = 8'h0C;
			STEP_W'(3): b = 8'h06;
			STEP_W'(4): b = 8'h01;
			default:    b = 8'h00;
		endcase
		return b;
	endfunction

	// ddram address command for a row
	function automatic logic [7:0] row_cmd(input logic [ROW_W-1:0] r);
		return (r == '0) ? CMD_ROW_ONE : CMD_ROW_TWO;
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/lcdbuf_cell.sv -----
// ---------------------------------------------------------------------------
// lcdbuf_cell: one character cell of the shadow buffer
// Holds one byte; loads a space on clear, its neighbour's byte on shift,
// or the written character when addressed.
// ---------------------------------------------------------------------------
`default_nettype none

module lcdbuf_cell (
	input  wire                     clk,
	input  wire                     arst_n,
	input  lcdbuf_pkg::cell_ctrl_t  ctrl,
	input  wire                     wr_hit,
	input  wire  [7:0]              nb_data,
	output logic [7:0]              data
);
	import lcdbuf_pkg::*;

	logic [7:0] data_q;

	// cell byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_q <= '0;
		end else if (ctrl.clear) begin
			data_q <= CHAR_SPACE;
		end else if (ctrl.shift) begin
			data_q <= nb_data;
		end else if (wr_hit) begin
			data_q <= ctrl.char_code;
		end
	end

	assign data = data_q;

endmodule

`default_nettype wire

// ----- hw/rtl/lcdbuf_chain.sv -----
// ---------------------------------------------------------------------------
// lcdbuf_chain: ring of character cells
// Cells sit in row-major order; a shift rotates the ring by one so the
// head cell presents the next character, and a full turn restores order.
// ---------------------------------------------------------------------------
`default_nettype none

module lcdbuf_chain (
	input  wire                     clk,
	input  wire                     arst_n,
	input  lcdbuf_pkg::cell_ctrl_t  ctrl,
	output logic [7:0]              head
);
	import lcdbuf_pkg::*;

	logic [7:0] cell_data [CELLS];

	// ring of cells, each fed by its successor
	for (genvar i = 0; i < CELLS; i++) begin : g_cell
		localparam int NXT = (i + 1) % CELLS;
		logic hit;

		assign hit = ctrl.wr_en && (ctrl.wr_index == CELL_W'(i));

		lcdbuf_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctrl    (ctrl),
			.wr_hit  (hit),
			.nb_data (cell_data[NXT]),
			.data    (cell_data[i])
		);
	end

	assign head = cell_data[0];

endmodule

`default_nettype wire

// ----- hw/rtl/char_lcd_buffer_refresh.sv -----
// ---------------------------------------------------------------------------
// char_lcd_buffer_refresh: shadow text buffer and lcd transfer sequencer
// Keeps the display text in a ring of cells and turns each operation into
// command, data and status beats for the pin stage.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+------------------
//   item     | item_valid / item_stall    | item   (item_t)
//   result   | result_valid / result_stall| result (result_t)
//
// Init gives 5 result beats, write and clear 1, refresh ROWS*(COLUMNS+1)
// (42 here), one beat per cycle while result is not stalled; the next item
// is taken once the sequencer is back in idle and the output can load.
// During refresh the cell ring rotates one position per data beat.
// Reset clears the buffer to zero, the pending flag and the sequencer.
// A stalled result holds in the output register and freezes the sequencer.
// ---------------------------------------------------------------------------
`default_nettype none

module char_lcd_buffer_refresh (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  item_valid,
	output logic                 item_stall,
	input  lcdbuf_pkg::item_t    item,
	output logic                 result_valid,
	input  wire                  result_stall,
	output lcdbuf_pkg::result_t  result
);
	import lcdbuf_pkg::*;

	state_t             state_q, state_d;
	logic [STEP_W-1:0]  step_q, step_d;
	logic [COL_W-1:0]   col_q, col_d;
	logic [ROW_W-1:0]   row_q, row_d;
	logic               cmd_q, cmd_d;
	logic               pending_q, pending_d;
	logic               out_valid_q;
	result_t            out_q;

	logic               load_ok;
	logic               accept;
	logic               emit;
	result_t            emit_beat;
	cell_ctrl_t         ctrl;
	logic [7:0]         head;
	logic               in_grid;
	logic [CELL_W-1:0]  wr_index;

	lcdbuf_chain u_chain (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.head   (head)
	);

	// handshake
	assign load_ok    = !out_valid_q || !result_stall;
	assign item_stall = (state_q != ST_IDLE) || !load_ok;
	assign accept     = item_valid && !item_stall;

	// write address decode
	assign in_grid = (item.column != 5'd0) && (32'(item.column) <= COLUMNS) &&
	                 (item.row != 2'd0) && (32'(item.row) <= ROWS);
	assign wr_index = (item.row == 2'd2)
	                ? CELL_W'(COLUMNS) + CELL_W'(item.column) - CELL_W'(1)
	                : CELL_W'(item.column) - CELL_W'(1);

	// sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			step_q    <= '0;
			col_q     <= '0;
			row_q     <= '0;
			cmd_q     <= 1'b0;
			pending_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			step_q    <= step_d;
			col_q     <= col_d;
			row_q     <= row_d;
			cmd_q     <= cmd_d;
			pending_q <= pending_d;
		end
	end

	// next state and beat generation
	always_comb begin
		state_d   = state_q;
		step_d    = step_q;
		col_d     = col_q;
		row_d     = row_q;
		cmd_d     = cmd_q;
		pending_d = pending_q;
		emit      = 1'b0;
		emit_beat = '0;
		ctrl      = '0;
		ctrl.wr_index  = wr_index;
		ctrl.char_code = item.char_code;

		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					emit = 1'b1;
					case (item.op)
						OP_INIT: begin
							emit_beat.has_transfer    = 1'b1;
							emit_beat.bus_byte        = init_byte('0);
							emit_beat.nibble_only     = 1'b1;
							emit_beat.refresh_pending = pending_q;
							step_d  = STEP_W'(1);
							state_d = ST_INIT;
						end
						OP_WRITE: begin
							ctrl.wr_en = in_grid;
							pending_d  = 1'b1;
							emit_beat.refresh_pending = 1'b1;
							emit_beat.last            = 1'b1;
						end
						OP_CLEAR: begin
							ctrl.clear = 1'b1;
							pending_d  = 1'b1;
							emit_beat.refresh_pending = 1'b1;
							emit_beat.last            = 1'b1;
						end
						OP_REFRESH: begin
							pending_d = 1'b0;
							emit_beat.has_transfer = 1'b1;
							emit_beat.bus_byte     = row_cmd('0);
							col_d   = '0;
							row_d   = '0;
							cmd_d   = 1'b0;
							state_d = ST_REFRESH;
						end
						default: begin
							emit = 1'b0;
						end
					endcase
				end
			end

			ST_INIT: begin
				if (load_ok) begin
					emit = 1'b1;
					emit_beat.has_transfer    = 1'b1;
					emit_beat.bus_byte        = init_byte(step_q);
					emit_beat.refresh_pending = pending_q;
					emit_beat.last            = (step_q == STEP_W'(INIT_LEN - 1));
					step_d = step_q + STEP_W'(1);
					if (step_q == STEP_W'(INIT_LEN - 1)) begin
						step_d  = '0;
						state_d = ST_IDLE;
					end
				end
			end

			ST_REFRESH: begin
				if (load_ok) begin
					emit = 1'b1;
					emit_beat.has_transfer = 1'b1;
					if (cmd_q) begin
						// row address command
						emit_beat.bus_byte = row_cmd(row_q);
						cmd_d = 1'b0;
					end else begin
						// data beat from the head cell, ring advances
						emit_beat.register_select = 1'b1;
						emit_beat.bus_byte        = head;
						ctrl.shift = 1'b1;
						col_d = col_q + COL_W'(1);
						if (col_q == COL_W'(COLUMNS - 1)) begin
							col_d = '0;
							if (row_q == ROW_W'(ROWS - 1)) begin
								emit_beat.last = 1'b1;
								row_d   = '0;
								state_d = ST_IDLE;
							end else begin
								row_d = row_q + ROW_W'(1);
								cmd_d = 1'b1;
							end
						end
					end
				end
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q <= emit_beat;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

	// checks
	a_refresh_not_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_REFRESH) |-> !pending_q)
		else $error("pending flag set during refresh");

	a_accept_gives_beat: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_valid_q)
		else $error("accepted item produced no result beat");

	a_ctrl_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({ctrl.shift, ctrl.clear, ctrl.wr_en}))
		else $error("conflicting cell controls");

	a_init_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_INIT) |-> (step_q != '0 && step_q < STEP_W'(INIT_LEN)))
		else $error("init step out of range");

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_REFRESH) |-> (32'(col_q) < COLUMNS))
		else $error("refresh column out of range");

endmodule

`default_nettype wire

// ----- tb/tb_char_lcd_buffer_refresh.sv -----
// ---------------------------------------------------------------------------
// tb_char_lcd_buffer_refresh: self-checking bench for the lcd buffer sequencer
// A queue-fed driver offers operations with random gaps. A shadow copy of the
// text buffer and pending flag predicts every command, data and status beat.
// A monitor with random stalls, plus one long hold-off, compares each beat
// field by field against the oldest prediction.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_char_lcd_buffer_refresh;

	import lcdbuf_pkg::*;

	localparam int IDLE_PCT       = 27;
	localparam int HOLD_LEN       = 400;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int SETTLE_CYCLES  = 60;

	// controller wake-up bytes, index 0 strobed as a lone high nibble
	localparam logic [4:0][7:0] WAKE_SEQ = {8'h01, 8'h06, 8'h0C, 8'h2C, 8'h20};

	logic    clk          = 1'b0;
	logic    arst_n       = 1'b0;
	logic    item_valid   = 1'b0;
	logic    item_stall;
	item_t   item         = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result;

	// stimulus and prediction stores
	item_t   pending_items[$];
	result_t expected_beats[$];
	logic [7:0] shadow_text [CELLS];
	logic    shadow_pending = 1'b0;

	// run control and bookkeeping
	logic    no_idle    = 1'b0;
	logic    want_hold  = 1'b0;
	logic    hold_taken = 1'b0;
	int      hold_left  = 0;
	int      quiet_cycles = 0;
	int      fail_count   = 0;
	int      items_done   = 0;
	int      beats_checked = 0;
	int      refresh_count = 0;
	int      off_grid_writes = 0;

	char_lcd_buffer_refresh u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// build one predicted beat, pending flag taken from the shadow state
	function automatic result_t lcd_beat(input logic xfer, input logic rs,
			input logic [7:0] b, input logic nib, input logic fin);
		result_t r;
		r.has_transfer    = xfer;
		r.register_select = rs;
		r.bus_byte        = b;
		r.nibble_only     = nib;
		r.refresh_pending = shadow_pending;
		r.last            = fin;
		return r;
	endfunction

	// apply one operation to the shadow buffer and queue its beats
	task automatic lcd_apply_op(input item_t it);
		int idx;
		case (it.op)
			OP_INIT: begin
				for (int i = 0; i < INIT_LEN; i++)
					expected_beats.push_back(lcd_beat(1'b1, 1'b0, WAKE_SEQ[i],
						i == 0, i == INIT_LEN - 1));
			end
			OP_WRITE: begin
				shadow_pending = 1'b1;
				if (it.column >= 1 && it.column <= COLUMNS &&
						it.row >= 1 && it.row <= ROWS) begin
					idx = (int'(it.row) - 1) * COLUMNS + int'(it.column) - 1;
					shadow_text[idx] = it.char_code;
				end else begin
					off_grid_writes++;
				end
				expected_beats.push_back(lcd_beat(1'b0, 1'b0, 8'h00, 1'b0, 1'b1));
			end
			OP_CLEAR: begin
				shadow_pending = 1'b1;
				for (int i = 0; i < CELLS; i++)
					shadow_text[i] = CHAR_SPACE;
				expected_beats.push_back(lcd_beat(1'b0, 1'b0, 8'h00, 1'b0, 1'b1));
			end
			default: begin
				// refresh: row address command, then that row's cells
				shadow_pending = 1'b0;
				refresh_count++;
				for (int r = 0; r < ROWS; r++) begin
					expected_beats.push_back(lcd_beat(1'b1, 1'b0,
						(r == 0) ? CMD_ROW_ONE : CMD_ROW_TWO, 1'b0, 1'b0));
					for (int c = 0; c < COLUMNS; c++)
						expected_beats.push_back(lcd_beat(1'b1, 1'b1,
							shadow_text[r * COLUMNS + c], 1'b0,
							r == ROWS - 1 && c == COLUMNS - 1));
				end
			end
		endcase
	endtask

	task automatic check_field(input string name, input int exp_val, input int act_val);
		if (exp_val != act_val) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
			fail_count++;
		end
	endtask

	// driver: when the slot is free, take the next operation from the queue or idle at random
	always @(posedge clk) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else begin
			if (item_valid && !item_stall) begin
				lcd_apply_op(item);
				items_done++;
			end
			if (!item_valid || !item_stall) begin
				if (pending_items.size() > 0 &&
						(no_idle || $urandom_range(99) >= IDLE_PCT)) begin
					item       <= pending_items.pop_front();
					item_valid <= 1'b1;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: check each accepted beat, then pick the next stall
	always @(posedge clk) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else begin
			if (result_valid && !result_stall) begin
				beats_checked++;
				if (expected_beats.size() == 0) begin
					$error("result beat with nothing expected: 0x%0h", result);
					fail_count++;
				end else begin
					result_t exp_beat;
					exp_beat = expected_beats.pop_front();
					check_field("has_transfer", exp_beat.has_transfer, result.has_transfer);
					check_field("register_select", exp_beat.register_select,
						result.register_select);
					check_field("bus_byte", exp_beat.bus_byte, result.bus_byte);
					check_field("nibble_only", exp_beat.nibble_only, result.nibble_only);
					check_field("refresh_pending", exp_beat.refresh_pending,
						result.refresh_pending);
					check_field("last", exp_beat.last, result.last);
				end
			end
			// long hold-off requested once, counted here
			if (want_hold && !hold_taken) begin
				hold_taken   <= 1'b1;
				hold_left    <= HOLD_LEN;
				result_stall <= 1'b1;
			end else if (hold_left > 0) begin
				hold_left    <= hold_left - 1;
				result_stall <= 1'b1;
			end else begin
				result_stall <= !no_idle && ($urandom_range(99) < IDLE_PCT);
			end
		end
	end

	// watchdog on cycles with no beat on either channel
	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout after %0d quiet cycles", quiet_cycles);
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic push_item(input op_t op, input logic [4:0] col, input logic [1:0] row,
			input logic [7:0] ch);
		item_t it;
		it.op        = op;
		it.column    = col;
		it.row       = row;
		it.char_code = ch;
		pending_items.push_back(it);
	endtask

	// mostly in-grid writes with random refreshes, clears and inits, some off-grid noise
	function automatic item_t random_op();
		item_t it;
		int pick;
		it.column    = 5'($urandom);
		it.row       = 2'($urandom);
		it.char_code = 8'($urandom);
		pick = $urandom_range(99);
		if (pick < 6) begin
			it.op = OP_INIT;
		end else if (pick < 10) begin
			it.op = OP_CLEAR;
		end else if (pick < 20) begin
			it.op = OP_REFRESH;
		end else begin
			it.op = OP_WRITE;
			if (pick < 90) begin
				it.column = 5'($urandom_range(COLUMNS, 1));
				it.row    = 2'($urandom_range(ROWS, 1));
			end
		end
		return it;
	endfunction

	task automatic push_random(input int count);
		for (int i = 0; i < count; i++)
			pending_items.push_back(random_op());
	endtask

	// sender pause until every predicted beat has come back
	task automatic wait_for_drain();
		@(negedge clk);
		while (pending_items.size() != 0 || item_valid || expected_beats.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		for (int i = 0; i < CELLS; i++)
			shadow_text[i] = 8'h00;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: reset contents, wake-up, grid corners, off-grid writes, clears
		@(negedge clk);
		push_item(OP_REFRESH, 5'd0, 2'd0, 8'h00);
		push_item(OP_INIT, 5'h1F, 2'd3, 8'hFF);
		push_item(OP_WRITE, 5'd1, 2'd1, 8'hFF);
		push_item(OP_WRITE, 5'd20, 2'd2, 8'h00);
		push_item(OP_WRITE, 5'd20, 2'd1, 8'hA5);
		push_item(OP_WRITE, 5'd1, 2'd2, 8'h5A);
		push_item(OP_WRITE, 5'd0, 2'd1, 8'h41);
		push_item(OP_WRITE, 5'd21, 2'd1, 8'h42);
		push_item(OP_WRITE, 5'h1F, 2'd2, 8'h43);
		push_item(OP_WRITE, 5'd5, 2'd0, 8'h44);
		push_item(OP_WRITE, 5'd5, 2'd3, 8'h45);
		push_item(OP_REFRESH, 5'h1F, 2'd3, 8'hFF);
		push_item(OP_REFRESH, 5'd0, 2'd0, 8'h00);
		push_item(OP_CLEAR, 5'h15, 2'd2, 8'hC3);
		push_item(OP_WRITE, 5'd10, 2'd2, 8'h7E);
		push_item(OP_REFRESH, 5'd3, 2'd1, 8'h11);
		push_item(OP_CLEAR, 5'd0, 2'd0, 8'h00);
		push_item(OP_CLEAR, 5'h1F, 2'd3, 8'hFF);
		push_item(OP_INIT, 5'd0, 2'd0, 8'h00);
		push_item(OP_REFRESH, 5'd0, 2'd0, 8'h00);
		wait_for_drain();

		// random traffic with idling on both sides
		push_random(150);
		wait_for_drain();

		// long receiver hold-off while the sender keeps offering
		want_hold = 1'b1;
		push_random(60);
		wait_for_drain();

		// stretch with no idling at all
		no_idle = 1'b1;
		push_random(100);
		wait_for_drain();
		no_idle = 1'b0;

		push_random(120);
		wait_for_drain();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("ran %0d operations, %0d beats checked", items_done, beats_checked);
		$display("%0d refreshes, %0d writes outside the grid", refresh_count,
			off_grid_writes);
		if (fail_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

`default_nettype wire

// ----- char_lcd_buffer_refresh.f -----
hw/rtl/lcdbuf_pkg.sv
hw/rtl/lcdbuf_cell.sv
hw/rtl/lcdbuf_chain.sv
hw/rtl/char_lcd_buffer_refresh.sv
tb/tb_char_lcd_buffer_refresh.sv
